// ===== hw/rtl/rtcsbi_pkg.sv =====
// ----------------------------------------------------------------------------
// rtcsbi_pkg
// Shared constants, types and the BCD helper of the serial RTC bit interface.
// ----------------------------------------------------------------------------
`default_nettype none

package rtcsbi_pkg;

	// frame layout: four address bits, then eight data bits
	localparam int unsigned ADDR_BITS  = 4;
	localparam int unsigned DATA_BITS  = 8;
	localparam int unsigned FRAME_BITS = ADDR_BITS + DATA_BITS;
	localparam int unsigned PHASE_W    = $clog2(FRAME_BITS);

	// clock register file
	localparam int unsigned REG_COUNT  = 10;
	localparam int unsigned TIME_REGS  = 8;
	localparam int unsigned TIME_BASE  = 2;
	localparam int unsigned STATUS_REG = 1;
	localparam int unsigned CTRL_REG   = 0;
	localparam int unsigned LOCK_BIT   = 4;

	localparam logic [DATA_BITS-1:0] REG_RESET = 8'hFF;

	// address commands
	localparam logic [ADDR_BITS-1:0] CMD_TO_CLOCK   = 4'hE;
	localparam logic [ADDR_BITS-1:0] CMD_FROM_CLOCK = 4'hF;

	// access kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	typedef logic [DATA_BITS-1:0] byte_t;
	typedef byte_t [TIME_REGS-1:0] time_bytes_t;

	// register file update request from the sequencer
	typedef struct packed {
		logic                 wr_en;
		logic [ADDR_BITS-1:0] wr_addr;
		byte_t                wr_data;
		logic                 clr_status;
		logic                 load_time;
	} reg_cmd_t;

	// binary to packed BCD, kept to eight bits; v/10 by reciprocal 205/2048
	function automatic byte_t bcd8(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  q;
		logic [6:0]  r;
		prod = 15'(v) * 15'd205;
		q    = prod[14:11];
		r    = v - 7'(7'(q) * 7'd10);
		return byte_t'({q, 4'b0000}) + byte_t'({4'b0000, r[3:0]});
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rtc_serial_bit_interface_unit.sv =====
// ----------------------------------------------------------------------------
// rtc_serial_bit_interface_unit - serial RTC bit interface, one bit per transaction.
// Result path: stage 1 input register, then the result register; a stalled result holds stage 1.
// Throughput: one transaction per cycle unless out_ready stalls the result; state is updated as each leaves stage 1.
// Reset: arst_n clears the frame sequencer, all clock registers to 0xFF.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_serial_bit_interface_unit
	import rtcsbi_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       req_type,
	input  wire logic       write_bit,
	input  wire logic [5:0] now_seconds,
	input  wire logic [5:0] now_minutes,
	input  wire logic [4:0] now_hours,
	input  wire logic [4:0] now_day,
	input  wire logic [3:0] now_month,
	input  wire logic [6:0] now_year,
	input  wire logic [2:0] now_weekday,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            read_bit
);

	// stage 1 input register
	logic       valid_s1;
	logic       req_type_s1;
	logic       write_bit_s1;
	logic [5:0] now_seconds_s1;
	logic [5:0] now_minutes_s1;
	logic [4:0] now_hours_s1;
	logic [4:0] now_day_s1;
	logic [3:0] now_month_s1;
	logic [6:0] now_year_s1;
	logic [2:0] now_weekday_s1;

	// frame state
	logic [PHASE_W-1:0]   bit_phase_q, bit_phase_d;
	logic [ADDR_BITS-1:0] reg_address_q, reg_address_d;
	byte_t                shift_q, shift_d;

	// result register
	logic out_valid_q;
	logic read_bit_q;
	logic result_d;

	logic                 advance;
	logic [PHASE_W-1:0]   phase_inc;
	logic [ADDR_BITS-1:0] addr_shifted;
	byte_t                shift_src;
	byte_t                rd_data;
	time_bytes_t          time_bytes;
	reg_cmd_t             reg_cmd;

	// handshake: stage 1 moves on when the result register is free or drains
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign read_bit  = read_bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1    <= req_type;
			write_bit_s1   <= write_bit;
			now_seconds_s1 <= now_seconds;
			now_minutes_s1 <= now_minutes;
			now_hours_s1   <= now_hours;
			now_day_s1     <= now_day;
			now_month_s1   <= now_month;
			now_year_s1    <= now_year;
			now_weekday_s1 <= now_weekday;
		end
	end

	rtcsbi_time_conv u_time_conv (
		.now_seconds (now_seconds_s1),
		.now_minutes (now_minutes_s1),
		.now_hours   (now_hours_s1),
		.now_day     (now_day_s1),
		.now_month   (now_month_s1),
		.now_year    (now_year_s1),
		.now_weekday (now_weekday_s1),
		.time_bytes  (time_bytes)
	);

	rtcsbi_clock_regs u_clock_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (reg_cmd),
		.time_bytes (time_bytes),
		.rd_addr    (reg_address_q),
		.rd_data    (rd_data)
	);

	// frame sequencer
	assign phase_inc    = bit_phase_q + PHASE_W'(1);
	assign addr_shifted = {write_bit_s1, reg_address_q[ADDR_BITS-1:1]};
	assign shift_src    = (bit_phase_q == PHASE_W'(ADDR_BITS)) ? rd_data : shift_q;

	always_comb begin
		bit_phase_d   = bit_phase_q;
		reg_address_d = reg_address_q;
		shift_d       = shift_q;
		result_d      = 1'b0;
		reg_cmd       = '0;
		if (advance) begin
			if (req_type_s1 == REQ_READ) begin
				if (bit_phase_q < PHASE_W'(ADDR_BITS)) begin
					// read in the address phase aborts it
					bit_phase_d = '0;
				end else begin
					result_d    = shift_src[0];
					shift_d     = shift_src >> 1;
					bit_phase_d = (phase_inc >= PHASE_W'(FRAME_BITS)) ? '0 : phase_inc;
				end
			end else if (bit_phase_q < PHASE_W'(ADDR_BITS)) begin
				reg_address_d = addr_shifted;
				bit_phase_d   = phase_inc;
				if (phase_inc == PHASE_W'(ADDR_BITS) && addr_shifted >= CMD_TO_CLOCK) begin
					reg_cmd.clr_status = (addr_shifted == CMD_TO_CLOCK);
					reg_cmd.load_time  = (addr_shifted == CMD_FROM_CLOCK);
					bit_phase_d        = '0;
				end
			end else begin
				shift_d     = {write_bit_s1, shift_q[DATA_BITS-1:1]};
				bit_phase_d = phase_inc;
				if (phase_inc >= PHASE_W'(FRAME_BITS)) begin
					reg_cmd.wr_en   = 1'b1;
					reg_cmd.wr_addr = reg_address_q;
					reg_cmd.wr_data = {write_bit_s1, shift_q[DATA_BITS-1:1]};
					reg_address_d   = '0;
					bit_phase_d     = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_phase_q   <= '0;
			reg_address_q <= '0;
			shift_q       <= '0;
		end else begin
			bit_phase_q   <= bit_phase_d;
			reg_address_q <= reg_address_d;
			shift_q       <= shift_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_bit_q <= result_d;
		end
	end

	// checks
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_phase_q < PHASE_W'(FRAME_BITS))
		else $error("bit phase beyond frame");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("stage 1 accepted while result stalled");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("transaction produced no result");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && req_type_s1 == REQ_WRITE) |=> !read_bit_q)
		else $error("write returned a one bit");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({reg_cmd.wr_en, reg_cmd.clr_status, reg_cmd.load_time}) <= 1)
		else $error("conflicting register updates");

endmodule

`default_nettype wire

// ===== hw/rtl/rtcsbi_time_conv.sv =====
// ----------------------------------------------------------------------------
// rtcsbi_time_conv
// Converts the binary current-time fields into the TIME_REGS clock register bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcsbi_time_conv
	import rtcsbi_pkg::*;
(
	input  wire logic [5:0] now_seconds,
	input  wire logic [5:0] now_minutes,
	input  wire logic [4:0] now_hours,
	input  wire logic [4:0] now_day,
	input  wire logic [3:0] now_month,
	input  wire logic [6:0] now_year,
	input  wire logic [2:0] now_weekday,
	output time_bytes_t     time_bytes
);

	// register order: sec, min, hour, day, month, year, weekday, day again
	always_comb begin
		time_bytes[0] = bcd8(7'(now_seconds));
		time_bytes[1] = bcd8(7'(now_minutes));
		time_bytes[2] = bcd8(7'(now_hours));
		time_bytes[3] = bcd8(7'(now_day));
		time_bytes[4] = bcd8(7'(now_month));
		time_bytes[5] = bcd8(now_year);
		time_bytes[6] = byte_t'(now_weekday);
		time_bytes[7] = bcd8(7'(now_day));
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rtcsbi_clock_regs.sv =====
// ----------------------------------------------------------------------------
// rtcsbi_clock_regs
// REG_COUNT clock registers with byte write, status clear and time load.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcsbi_clock_regs
	import rtcsbi_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire reg_cmd_t             cmd,
	input  wire time_bytes_t          time_bytes,
	input  wire logic [ADDR_BITS-1:0] rd_addr,
	output byte_t                     rd_data
);

	byte_t regs_q [REG_COUNT];
	byte_t change_mask;

	// read port: unmapped addresses read all ones
	always_comb begin
		if (rd_addr < ADDR_BITS'(REG_COUNT)) begin
			rd_data = regs_q[rd_addr];
		end else begin
			rd_data = REG_RESET;
		end
	end

	// one status bit per time register that differs from the new time
	always_comb begin
		for (int i = 0; i < TIME_REGS; i++) begin
			change_mask[i] = (regs_q[TIME_BASE + i] != time_bytes[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				regs_q[i] <= REG_RESET;
			end
		end else if (cmd.load_time) begin
			regs_q[CTRL_REG]   <= '0;
			regs_q[STATUS_REG] <= change_mask;
			for (int i = 0; i < TIME_REGS; i++) begin
				regs_q[TIME_BASE + i] <= time_bytes[i];
			end
		end else if (cmd.clr_status) begin
			// lock bit in the control register protects the status byte from this clear
			if (!regs_q[CTRL_REG][LOCK_BIT]) begin
				regs_q[STATUS_REG] <= '0;
			end
		end else if (cmd.wr_en && (cmd.wr_addr < ADDR_BITS'(REG_COUNT))) begin
			regs_q[cmd.wr_addr] <= cmd.wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== tb/rtcsbi_access_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcsbi_access_checker
// Watches both channels of the serial RTC bit interface. It keeps its own
// copy of the frame sequencer and clock registers, works out the read bit of
// every accepted access and compares it, in order, with the returned ones.
// ----------------------------------------------------------------------------

module rtcsbi_access_checker
	import rtcsbi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       req_type,
	input  logic       write_bit,
	input  logic [5:0] now_seconds,
	input  logic [5:0] now_minutes,
	input  logic [4:0] now_hours,
	input  logic [4:0] now_day,
	input  logic [3:0] now_month,
	input  logic [6:0] now_year,
	input  logic [2:0] now_weekday,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       read_bit,
	output int         fail_count,
	output int         pending_count
);

	// predicted device state
	logic [3:0] frame_pos;
	logic [3:0] addr_sr;
	byte_t      data_sr;
	byte_t      rtc_regs [REG_COUNT];

	logic       expected_read_bits [$];
	logic       want_bit;
	int         mismatch_total;

	// packed BCD of a binary count, truncated to a byte
	function automatic byte_t to_bcd(input int unsigned v);
		return byte_t'(((v / 10) << 4) + (v % 10));
	endfunction

	// advance the predicted state by one access and return its read bit
	function automatic logic compute_read_bit(input logic rd, input logic wb,
			input logic [5:0] sec, input logic [5:0] mins, input logic [4:0] hrs,
			input logic [4:0] dom, input logic [3:0] mon, input logic [6:0] yr,
			input logic [2:0] wday);
		logic  bit_out;
		byte_t fresh [TIME_REGS];
		bit_out = 1'b0;
		if (rd == REQ_READ) begin
			// a read in the address phase just restarts the frame
			if (frame_pos < ADDR_BITS) begin
				frame_pos = '0;
			end else begin
				if (frame_pos == ADDR_BITS)
					data_sr = (addr_sr < REG_COUNT) ? rtc_regs[addr_sr] : REG_RESET;
				frame_pos = frame_pos + 1'b1;
				if (frame_pos >= FRAME_BITS)
					frame_pos = '0;
				bit_out = data_sr[0];
				data_sr = data_sr >> 1;
			end
		end else if (frame_pos < ADDR_BITS) begin
			// address bits arrive LSB first
			addr_sr   = {wb, addr_sr[3:1]};
			frame_pos = frame_pos + 1'b1;
			if (frame_pos == ADDR_BITS && addr_sr >= CMD_TO_CLOCK) begin
				if (addr_sr == CMD_TO_CLOCK) begin
					if (!rtc_regs[CTRL_REG][LOCK_BIT])
						rtc_regs[STATUS_REG] = '0;
				end else begin
					fresh[0] = to_bcd(sec);
					fresh[1] = to_bcd(mins);
					fresh[2] = to_bcd(hrs);
					fresh[3] = to_bcd(dom);
					fresh[4] = to_bcd(mon);
					fresh[5] = to_bcd(yr);
					fresh[6] = byte_t'(wday);
					fresh[7] = to_bcd(dom);
					rtc_regs[CTRL_REG]   = '0;
					rtc_regs[STATUS_REG] = '0;
					for (int i = 0; i < TIME_REGS; i++) begin
						if (rtc_regs[TIME_BASE + i] != fresh[i]) begin
							rtc_regs[TIME_BASE + i]  = fresh[i];
							rtc_regs[STATUS_REG][i] = 1'b1;
						end
					end
				end
				frame_pos = '0;
			end
		end else begin
			// data bits enter at the top of the shifter
			data_sr   = {wb, data_sr[7:1]};
			frame_pos = frame_pos + 1'b1;
			if (frame_pos >= FRAME_BITS) begin
				if (addr_sr < REG_COUNT)
					rtc_regs[addr_sr] = data_sr;
				addr_sr   = '0;
				frame_pos = '0;
			end
		end
		return bit_out;
	endfunction

	// predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos = '0;
			addr_sr   = '0;
			data_sr   = '0;
			for (int i = 0; i < REG_COUNT; i++)
				rtc_regs[i] = REG_RESET;
			expected_read_bits.delete();
			mismatch_total = 0;
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_read_bits.push_back(compute_read_bit(req_type, write_bit,
					now_seconds, now_minutes, now_hours, now_day, now_month,
					now_year, now_weekday));
			if (out_valid && out_ready) begin
				if (expected_read_bits.size() == 0) begin
					mismatch_total++;
					if (mismatch_total <= 10)
						$display("%0t: read_bit %0b returned with none outstanding",
							$time, read_bit);
				end else begin
					want_bit = expected_read_bits.pop_front();
					if (read_bit !== want_bit) begin
						mismatch_total++;
						if (mismatch_total <= 10)
							$display("%0t: read_bit expected %0b, got %0b",
								$time, want_bit, read_bit);
					end
				end
			end
			fail_count    <= mismatch_total;
			pending_count <= expected_read_bits.size();
		end
	end

endmodule

// ===== tb/rtc_serial_bit_interface_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_serial_bit_interface_unit_tb
// Drives serial bit accesses into the RTC interface: a few directed frames,
// then random address commands, register write, read and mixed frames and
// some broken sequences, with random gaps and back-pressure. The checker
// beside the block predicts and compares every returned bit.
// ----------------------------------------------------------------------------

module rtc_serial_bit_interface_unit_tb;
	import rtcsbi_pkg::*;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int TARGET_ITEMS = 1450;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic       req_type    = REQ_WRITE;
	logic       write_bit   = 1'b0;
	logic [5:0] now_seconds = '0;
	logic [5:0] now_minutes = '0;
	logic [4:0] now_hours   = '0;
	logic [4:0] now_day     = 5'd1;
	logic [3:0] now_month   = 4'd1;
	logic [6:0] now_year    = '0;
	logic [2:0] now_weekday = '0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	logic       read_bit;

	int         fail_count;
	int         pending_count;
	int         cycle_count = 0;
	int         sent        = 0;
	bit         calm        = 1'b0;

	// time of day presented with the next transactions
	logic [5:0] t_sec  = '0;
	logic [5:0] t_min  = '0;
	logic [4:0] t_hour = '0;
	logic [4:0] t_day  = 5'd1;
	logic [3:0] t_mon  = 4'd1;
	logic [6:0] t_year = '0;
	logic [2:0] t_wday = '0;

	rtc_serial_bit_interface_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.write_bit  (write_bit),
		.now_seconds(now_seconds),
		.now_minutes(now_minutes),
		.now_hours  (now_hours),
		.now_day    (now_day),
		.now_month  (now_month),
		.now_year   (now_year),
		.now_weekday(now_weekday),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_bit   (read_bit)
	);

	rtcsbi_access_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.write_bit    (write_bit),
		.now_seconds  (now_seconds),
		.now_minutes  (now_minutes),
		.now_hours    (now_hours),
		.now_day      (now_day),
		.now_month    (now_month),
		.now_year     (now_year),
		.now_weekday  (now_weekday),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_bit     (read_bit),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	// 2 ns clock
	initial begin
		forever #1 clk = ~clk;
	end

	// result back-pressure
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 31);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// one bit access; returns just after the accepting edge
	task automatic send_access(input logic rd, input logic wb);
		while (!calm && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= rd;
		write_bit   <= wb;
		now_seconds <= t_sec;
		now_minutes <= t_min;
		now_hours   <= t_hour;
		now_day     <= t_day;
		now_month   <= t_mon;
		now_year    <= t_year;
		now_weekday <= t_wday;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	// four address bits, LSB first
	task automatic send_address(input logic [3:0] addr);
		for (int i = 0; i < ADDR_BITS; i++)
			send_access(REQ_WRITE, addr[i]);
	endtask

	// mostly calendar-valid time, sometimes anything the port widths allow
	task automatic pick_time();
		if ($urandom_range(7) == 0) begin
			t_sec  = 6'($urandom_range(63));
			t_min  = 6'($urandom_range(63));
			t_hour = 5'($urandom_range(31));
			t_day  = 5'($urandom_range(31));
			t_mon  = 4'($urandom_range(15));
			t_year = 7'($urandom_range(127));
			t_wday = 3'($urandom_range(7));
		end else begin
			t_sec  = 6'($urandom_range(60));
			t_min  = 6'($urandom_range(59));
			t_hour = 5'($urandom_range(23));
			t_day  = 5'($urandom_range(31, 1));
			t_mon  = 4'($urandom_range(12, 1));
			t_year = 7'($urandom_range(99));
			t_wday = 3'($urandom_range(6));
		end
	endtask

	// stimulus
	initial begin
		int          kind;
		int          burst;
		logic [3:0]  addr;
		logic [7:0]  value;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// read part-way through an address aborts it
		send_access(REQ_WRITE, 1'b1);
		send_access(REQ_WRITE, 1'b0);
		send_access(REQ_READ, 1'b0);
		// load time at the top of every range
		t_sec  = 6'd60;
		t_min  = 6'd59;
		t_hour = 5'd23;
		t_day  = 5'd31;
		t_mon  = 4'd12;
		t_year = 7'd99;
		t_wday = 3'd6;
		send_address(CMD_FROM_CLOCK);
		// status clear, lock bit not set
		send_address(CMD_TO_CLOCK);
		// set the lock bit in the control register
		value = 8'h10;
		send_address(4'(CTRL_REG));
		for (int i = 0; i < 8; i++)
			send_access(REQ_WRITE, value[i]);

		// random frames
		while (sent < TARGET_ITEMS) begin
			calm = (sent >= 600 && sent < 800);
			kind = $urandom_range(99);
			if (kind < 18) begin
				pick_time();
				send_address(CMD_FROM_CLOCK);
			end else if (kind < 28) begin
				send_address(CMD_TO_CLOCK);
			end else if (kind < 45) begin
				// register write; bytes with the lock bit come up often
				addr  = 4'($urandom_range(13));
				value = 8'($urandom_range(255));
				send_address(addr);
				for (int i = 0; i < 8; i++)
					send_access(REQ_WRITE, value[i]);
			end else if (kind < 78) begin
				addr = 4'($urandom_range(13));
				send_address(addr);
				for (int i = 0; i < 8; i++)
					send_access(REQ_READ, 1'($urandom_range(1)));
			end else if (kind < 88) begin
				// reads and writes interleaved within one data phase
				addr = 4'($urandom_range(13));
				send_address(addr);
				for (int i = 0; i < 8; i++)
					send_access(1'($urandom_range(1)), 1'($urandom_range(1)));
			end else begin
				// broken sequence, then enough reads to land back on a frame start
				burst = $urandom_range(6, 1);
				for (int i = 0; i < burst; i++) begin
					pick_time();
					send_access(1'($urandom_range(1)), 1'($urandom_range(1)));
				end
				for (int i = 0; i < 8; i++)
					send_access(REQ_READ, 1'($urandom_range(1)));
			end
		end

		// drain
		calm = 1'b0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/rtcsbi_pkg.sv
hw/rtl/rtcsbi_time_conv.sv
hw/rtl/rtcsbi_clock_regs.sv
hw/rtl/rtc_serial_bit_interface_unit.sv
tb/rtcsbi_access_checker.sv
tb/rtc_serial_bit_interface_unit_tb.sv
